### rtl/peak_spectral_mask_pan_smooth_defines.svh
// ---------------------------------------------------------------------------
// peak_spectral_mask_pan_smooth_defines
// assertion macros for the peak spectral mask block
// ---------------------------------------------------------------------------
`ifndef PEAK_SPECTRAL_MASK_PAN_SMOOTH_DEFINES_SVH
`define PEAK_SPECTRAL_MASK_PAN_SMOOTH_DEFINES_SVH

// condition holds in the same cycle
`define PSM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define PSM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/psm_pkg.sv
// ---------------------------------------------------------------------------
// psm_pkg
// shared types and constants of the peak spectral mask block
// ---------------------------------------------------------------------------
package psm_pkg;

  localparam int DEF_FFT_SIZE  = 1024;
  localparam int DEF_MAX_PEAKS = 16;

  // smoothing gain end points in Q0.16
  localparam int GAIN_TOP  = 52429;
  localparam int GAIN_SPAN = 19661;

  // item operations
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_COUNT = 2'd1,
    OP_BIN   = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FG_ENABLE = 3'd0,
    CFG_FG_VOLUME = 3'd1,
    CFG_FG_PAN    = 3'd2,
    CFG_BG_ENABLE = 3'd3,
    CFG_BG_VOLUME = 3'd4,
    CFG_BG_PAN    = 3'd5
  } cfg_idx_t;

  // channel codes
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_RIGHT = 2'd2;

endpackage

### rtl/psm_item_if.sv
// ---------------------------------------------------------------------------
// psm_item_if
// input item channel of the peak spectral mask block
// ---------------------------------------------------------------------------
interface psm_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [3:0]         peak_slot;
  logic               peak_active;
  logic [15:0]        peak_bin_low;
  logic [15:0]        peak_bin_high;
  logic [15:0]        peak_volume;
  logic signed [15:0] peak_pan;
  logic [4:0]         peak_count;
  logic [9:0]         bin_index;
  logic signed [23:0] bin_value;
  logic [1:0]         channel_type;

  modport source (output valid, operation, peak_slot, peak_active, peak_bin_low,
                  peak_bin_high, peak_volume, peak_pan, peak_count, bin_index,
                  bin_value, channel_type, input ready);
  modport sink (input valid, operation, peak_slot, peak_active, peak_bin_low,
                peak_bin_high, peak_volume, peak_pan, peak_count, bin_index,
                bin_value, channel_type, output ready);
endinterface

### rtl/psm_result_if.sv
// ---------------------------------------------------------------------------
// psm_result_if
// result channel of the peak spectral mask block
// ---------------------------------------------------------------------------
interface psm_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] result_value;
  logic [9:0]         result_bin_index;
  logic [1:0]         result_channel;

  modport source (output valid, result_value, result_bin_index, result_channel,
                  input ready);
  modport sink (input valid, result_value, result_bin_index, result_channel,
                output ready);
endinterface

### rtl/psm_cfg_if.sv
// ---------------------------------------------------------------------------
// psm_cfg_if
// configuration write channel of the peak spectral mask block
// ---------------------------------------------------------------------------
interface psm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/peak_spectral_mask_pan_smooth.sv
// ---------------------------------------------------------------------------
// peak_spectral_mask_pan_smooth
// per-bin peak mask with pan and frame-to-frame smoothing, 7-stage pipeline
// ---------------------------------------------------------------------------
// path: a bin result passes stages 1 to 6 and the output register to reach the result channel
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: after rst the last-mask memory is cleared one entry a cycle, FFT_SIZE/2 entries
//   in all, during which no item is taken; configuration writes go on as ever
// smoothing read-modify-write runs through a separate read port and write port with forwarding
`include "peak_spectral_mask_pan_smooth_defines.svh"

module peak_spectral_mask_pan_smooth #(
  parameter int FFT_SIZE  = psm_pkg::DEF_FFT_SIZE,
  parameter int MAX_PEAKS = psm_pkg::DEF_MAX_PEAKS
) (
  input  logic   clk,
  input  logic   rst,
  psm_item_if.sink     item,
  psm_result_if.source result,
  psm_cfg_if.sink      cfg
);
  import psm_pkg::*;

  localparam int HALF = FFT_SIZE / 2;
  localparam int AW   = $clog2(HALF);
  localparam int LH   = $clog2(HALF);
  localparam int VPW  = $clog2(MAX_PEAKS + 1);

  // configuration registers
  logic               fg_enable, bg_enable;
  logic [15:0]        fg_volume, bg_volume;
  logic signed [15:0] fg_pan, bg_pan;

  // peak table
  logic               b_act [MAX_PEAKS];
  logic [15:0]        b_lo  [MAX_PEAKS];
  logic [15:0]        b_hi  [MAX_PEAKS];
  logic [15:0]        l_vol [MAX_PEAKS];
  logic signed [15:0] l_pan [MAX_PEAKS];
  logic [VPW-1:0]     valid_peaks;

  // last mask memory and clearing pass
  logic [15:0] mem [HALF];
  logic [AW:0] clr_cnt;
  logic        clearing;

  // pipeline control
  logic en, accept;

  // stage 1
  logic               s1_v;
  logic [1:0]         s1_op;
  logic [3:0]         s1_slot;
  logic               s1_act;
  logic [15:0]        s1_lo, s1_hi, s1_vol;
  logic signed [15:0] s1_pan;
  logic [4:0]         s1_cnt;
  logic [9:0]         s1_bin;
  logic signed [23:0] s1_val;
  logic [1:0]         s1_chan;
  logic [15:0]        s1_rd, s1_bd;
  logic               s1_byp;
  // stage 2
  logic                 s2_v, s2_low;
  logic [MAX_PEAKS-1:0] s2_hit;
  logic [15:0]          s2_g, s2_last;
  logic [9:0]           s2_bin;
  logic signed [23:0]   s2_val;
  logic [1:0]           s2_chan;
  // stage 3
  logic               s3_v, s3_low, s3_mono;
  logic [15:0]        s3_vol, s3_g, s3_last;
  logic [16:0]        s3_fac;
  logic [9:0]         s3_bin;
  logic signed [23:0] s3_val;
  logic [1:0]         s3_chan;
  // stage 4
  logic               s4_v, s4_low;
  logic [15:0]        s4_mask, s4_g, s4_last;
  logic [9:0]         s4_bin;
  logic signed [23:0] s4_val;
  logic [1:0]         s4_chan;
  // stage 5
  logic               s5_v, s5_low;
  logic [32:0]        s5_sum;
  logic [9:0]         s5_bin;
  logic signed [23:0] s5_val;
  logic [1:0]         s5_chan;
  // stage 6
  logic               s6_v, s6_low;
  logic signed [40:0] s6_prod;
  logic [9:0]         s6_bin;
  logic signed [23:0] s6_val;
  logic [1:0]         s6_chan;
  // output register
  logic               o_v;
  logic signed [23:0] o_val;
  logic [9:0]         o_bin;
  logic [1:0]         o_chan;

  // combinational helpers
  logic [15:0]        s1_last, s4_use, m;
  logic               pipe_we, mem_we;
  logic [AW-1:0]      mem_wa;
  logic [15:0]        mem_wd;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        pos;
  logic [MAX_PEAKS-1:0] hit;
  logic [31:0]        gdec;
  logic               found;
  logic [15:0]        pk_vol, sel_vol;
  logic signed [15:0] pk_pan, sel_pan;
  logic signed [17:0] fac_s;
  logic [32:0]        pan_prod;
  logic signed [26:0] shifted;
  logic signed [23:0] sat_val;

  // handshake and stall
  assign en           = !o_v || result.ready;
  assign clearing     = !clr_cnt[AW];
  assign item.ready   = en && !clearing;
  assign accept       = item.valid && item.ready;
  assign cfg.ready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_enable <= 1'b0;
      fg_volume <= '0;
      fg_pan    <= '0;
      bg_enable <= 1'b0;
      bg_volume <= '0;
      bg_pan    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FG_ENABLE: fg_enable <= cfg.data[0];
        CFG_FG_VOLUME: fg_volume <= cfg.data;
        CFG_FG_PAN:    fg_pan    <= $signed(cfg.data);
        CFG_BG_ENABLE: bg_enable <= cfg.data[0];
        CFG_BG_VOLUME: bg_volume <= cfg.data;
        CFG_BG_PAN:    bg_pan    <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // memory write and forward source
  assign m       = s5_sum[31:16];
  assign pipe_we = en && s5_v && s5_low;
  assign mem_we  = clearing || pipe_we;
  assign mem_wa  = clearing ? clr_cnt[AW-1:0] : AW'(s5_bin);
  assign mem_wd  = clearing ? 16'd0 : m;
  assign rd_addr = AW'(item.bin_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (en) begin
      s1_rd <= mem[rd_addr];
    end
  end

  // forwarding of the newest mask for a bin
  function automatic logic [15:0] fwd(input logic [15:0] last, input logic [9:0] bin,
                                      input logic we, input logic [AW-1:0] wa,
                                      input logic [15:0] wd);
    logic [15:0] r;
    r = (we && wa == AW'(bin)) ? wd : last;
    return r;
  endfunction

  assign s1_last = s1_byp ? s1_bd : s1_rd;
  assign s4_use  = fwd(s4_last, s4_bin, pipe_we, mem_wa, m);

  // stage 1: capture item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= item.operation;
      s1_slot <= item.peak_slot;
      s1_act  <= item.peak_active;
      s1_lo   <= item.peak_bin_low;
      s1_hi   <= item.peak_bin_high;
      s1_vol  <= item.peak_volume;
      s1_pan  <= item.peak_pan;
      s1_cnt  <= item.peak_count;
      s1_bin  <= item.bin_index;
      s1_val  <= item.bin_value;
      s1_chan <= item.channel_type;
      s1_byp  <= pipe_we && (mem_wa == rd_addr);
      s1_bd   <= m;
    end
  end

  // coverage compare and gain
  assign pos  = 32'(s1_bin) << 16;
  assign gdec = (32'(GAIN_SPAN) * (32'(HALF) - 32'(s1_bin))) >> LH;

  always_comb begin
    for (int j = 0; j < MAX_PEAKS; j++) begin
      hit[j] = (32'(j) < 32'(valid_peaks)) && b_act[j] &&
               (pos >= 32'(b_lo[j]) * 32'(FFT_SIZE)) &&
               (pos < 32'(b_hi[j]) * 32'(FFT_SIZE));
    end
  end

  // peak table and count updates
  always_ff @(posedge clk) begin
    if (en && s1_v && s1_op == OP_WRITE) begin
      for (int j = 0; j < MAX_PEAKS; j++) begin
        if (32'(s1_slot) == j) begin
          b_act[j] <= s1_act;
          b_lo[j]  <= s1_lo;
          b_hi[j]  <= s1_hi;
          l_vol[j] <= s1_vol;
          l_pan[j] <= s1_pan;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_peaks <= '0;
    end else if (en && s1_v && s1_op == OP_COUNT) begin
      valid_peaks <= (7'(s1_cnt) > 7'(MAX_PEAKS)) ? VPW'(MAX_PEAKS) : VPW'(s1_cnt);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && s1_op == OP_BIN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hit  <= hit;
      s2_g    <= 16'(32'(GAIN_TOP) - gdec);
      s2_last <= fwd(s1_last, s1_bin, pipe_we, mem_wa, m);
      s2_low  <= 32'(s1_bin) < 32'(HALF);
      s2_bin  <= s1_bin;
      s2_val  <= s1_val;
      s2_chan <= s1_chan;
    end
  end

  // priority pick of the first covering peak
  always_comb begin
    found  = 1'b0;
    pk_vol = '0;
    pk_pan = '0;
    for (int j = MAX_PEAKS - 1; j >= 0; j--) begin
      if (s2_hit[j]) begin
        found  = 1'b1;
        pk_vol = l_vol[j];
        pk_pan = l_pan[j];
      end
    end
  end

  // level and pan factor selection
  always_comb begin
    if (found) begin
      sel_vol = fg_enable ? fg_volume : pk_vol;
      sel_pan = fg_enable ? fg_pan : pk_pan;
    end else begin
      sel_vol = bg_enable ? bg_volume : 16'd0;
      sel_pan = bg_pan;
    end
    if (s2_chan == CH_LEFT) begin
      fac_s = 18'sd32768 - 18'(sel_pan);
    end else begin
      fac_s = 18'sd32768 + 18'(sel_pan);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vol  <= sel_vol;
      s3_fac  <= 17'(fac_s);
      s3_mono <= (s2_chan != CH_LEFT) && (s2_chan != CH_RIGHT);
      s3_g    <= s2_g;
      s3_last <= fwd(s2_last, s2_bin, pipe_we, mem_wa, m);
      s3_low  <= s2_low;
      s3_bin  <= s2_bin;
      s3_val  <= s2_val;
      s3_chan <= s2_chan;
    end
  end

  // pan scaling
  assign pan_prod = 33'(s3_vol) * 33'(s3_fac);

  // stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mask <= s3_mono ? s3_vol : pan_prod[31:16];
      s4_g    <= s3_g;
      s4_last <= fwd(s3_last, s3_bin, pipe_we, mem_wa, m);
      s4_low  <= s3_low;
      s4_bin  <= s3_bin;
      s4_val  <= s3_val;
      s4_chan <= s3_chan;
    end
  end

  // stage 5: smoothing against the last mask
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sum  <= 33'(s4_g) * 33'(s4_mask) + (33'd65536 - 33'(s4_g)) * 33'(s4_use);
      s5_low  <= s4_low;
      s5_bin  <= s4_bin;
      s5_val  <= s4_val;
      s5_chan <= s4_chan;
    end
  end

  // stage 6: apply mask to bin
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_prod <= s5_val * $signed({1'b0, m});
      s6_low  <= s5_low;
      s6_bin  <= s5_bin;
      s6_val  <= s5_val;
      s6_chan <= s5_chan;
    end
  end

  // floor shift and saturation
  always_comb begin
    shifted = 27'(s6_prod >>> 14);
    if (shifted > 27'sd8388607) begin
      sat_val = 24'sd8388607;
    end else if (shifted < -27'sd8388608) begin
      sat_val = -24'sd8388608;
    end else begin
      sat_val = 24'(shifted);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_val  <= s6_low ? sat_val : s6_val;
      o_bin  <= s6_bin;
      o_chan <= s6_chan;
    end
  end

  assign result.valid            = o_v;
  assign result.result_value     = o_val;
  assign result.result_bin_index = o_bin;
  assign result.result_channel   = o_chan;

  // checks
  `PSM_ASSERT_NOW(a_no_take_while_clearing, clk, rst, clearing, !item.ready, "item taken during clear")
  `PSM_ASSERT_NOW(a_pipe_wr_after_clear, clk, rst, pipe_we, !clearing, "mask write during clear")
  `PSM_ASSERT_NOW(a_stall_holds_input, clk, rst, result.valid && !result.ready, !item.ready, "input open while stalled")
  `PSM_ASSERT_NEXT(a_stall_holds_result, clk, rst, result.valid && !result.ready, result.valid && $stable(result.result_value), "result changed while stalled")

endmodule
